FILE: rtl/mmea_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmea_pkg
// Shared types, codes and helpers for the multi-pointer event accumulator.
// ----------------------------------------------------------------------------
package mmea_pkg;

  localparam int DEF_SLOT_COUNT   = 16;
  localparam int DEF_BUTTON_COUNT = 5;

  localparam int COORD_W   = 32;
  localparam int SLOT_W    = 4;
  localparam int KIND_W    = 2;
  localparam int BTN_IO_W  = 5;
  localparam int WDATA_W   = 16;
  localparam int CNT_W     = 5;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_EVENT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PEEK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = CNT_W;
  localparam logic [CFG_IDX_W-1:0] REG_INCLUDE_SYSTEM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INCLUDE_INDIV  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EVENT_SLOTS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_SLOTS    = 2'd3;

  localparam logic [CNT_W-1:0] RST_SLOT_COUNT = 5'd16;

  // system pointer only takes buttons 1 to 3
  localparam logic [BTN_IO_W-1:0] SYS_BUTTON_MASK = 5'b00111;
  localparam int MAX_EVENT_BUTTONS = 5;

  // reported bit positions of buttons 2 and 3
  localparam int BTN2_POS = 2;
  localparam int BTN3_POS = 1;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] move_x;
    logic signed [COORD_W-1:0] move_y;
    logic [BTN_IO_W-1:0]       buttons_down;
    logic [BTN_IO_W-1:0]       buttons_up;
    logic                      wheel_event;
    logic signed [WDATA_W-1:0] wheel_data;
    logic                      mark_absolute;
    logic                      mark_relative;
    logic                      mark_virtual_desktop;
  } item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] wheel_count;
    logic [BTN_IO_W-1:0]       button_bits;
    logic                      absolute_mode;
    logic                      virtual_desktop;
    logic                      slot_valid;
  } result_t;

  function automatic logic [COORD_W-1:0] wheel_step(
    input logic [COORD_W-1:0] count,
    input logic               wev,
    input logic [WDATA_W-1:0] wdata
  );
    logic [COORD_W-1:0] r;
    r = count;
    if (wev && (wdata != '0)) begin
      if (wdata[WDATA_W-1]) begin
        r = count - COORD_W'(1);
      end else begin
        r = count + COORD_W'(1);
      end
    end
    return r;
  endfunction

  function automatic logic [BTN_IO_W-1:0] remap_buttons(input logic [BTN_IO_W-1:0] b);
    logic [BTN_IO_W-1:0] r;
    r = b;
    r[BTN2_POS] = b[1];
    r[BTN3_POS] = b[2];
    return r;
  endfunction

endpackage

FILE: rtl/multi_mouse_event_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_mouse_event_accumulator
// Per-pointer slot table: events update the addressed slot and merge into
// the system pointer slot, queries return or read-and-clear a slot.
// ----------------------------------------------------------------------------
// query result: registered in the exec state and strobed on result_valid
// flow: busy is high for the cycle after accept, while the slot memory read
//   returns and the addressed slot is written back; the system slot merge is
//   written in the following cycle, forwarded to a next item accepted there
// reset: synchronous; slot valid bits clear at once, all slots read as zero,
//   registers return to both merges on and 16 event and query slots
// results are strobed for one cycle and cannot be held off
module multi_mouse_event_accumulator #(
  parameter int SLOT_COUNT   = mmea_pkg::DEF_SLOT_COUNT,
  parameter int BUTTON_COUNT = mmea_pkg::DEF_BUTTON_COUNT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  mmea_pkg::item_t                     item,
  output mmea_pkg::result_t                   result,
  output logic                                result_valid,
  input  logic                                cfg_we,
  input  logic [mmea_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mmea_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SW      = $clog2(SLOT_COUNT);
  localparam int BW      = BUTTON_COUNT;
  localparam int CW      = mmea_pkg::COORD_W;
  localparam int REC_W   = 3 * CW + BW + 2;
  localparam int X_LSB   = BW + 2 + 2 * CW;
  localparam int Y_LSB   = BW + 2 + CW;
  localparam int W_LSB   = BW + 2;
  localparam int B_LSB   = 2;
  localparam int BTN_EFF = (BW > mmea_pkg::MAX_EVENT_BUTTONS) ?
                           mmea_pkg::MAX_EVENT_BUTTONS : BW;
  localparam logic [BW-1:0] BTN_MASK = BW'((1 << BTN_EFF) - 1);
  localparam logic [BW-1:0] SYS_MASK = BW'(mmea_pkg::SYS_BUTTON_MASK);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]                   state;
  logic [1:0]                   state_next;
  mmea_pkg::item_t              cur;
  logic [SW-1:0]                cur_addr;
  logic                         cur_ev_ok;
  logic                         cur_q_ok;
  logic                         fwd_hit;
  logic [REC_W-1:0]             merge_rec;
  logic                         merge_we;

  logic                         include_system_pointer;
  logic                         include_individual;
  logic [mmea_pkg::CNT_W-1:0]   event_slot_count;
  logic [mmea_pkg::CNT_W-1:0]   query_slot_count;

  logic                         accept;
  logic                         in_table;
  logic                         ev_ok;
  logic                         q_ok;

  logic                         wr_en;
  logic [SW-1:0]                wr_addr;
  logic [REC_W-1:0]             wr_data;
  logic [REC_W-1:0]             rd_a;
  logic [REC_W-1:0]             rd_b;

  logic [REC_W-1:0]             rec_s;
  logic [REC_W-1:0]             rec_0;
  logic [CW-1:0]                s_x, s_y, s_w;
  logic [BW-1:0]                s_btn;
  logic                         s_abs, s_vd;
  logic [CW-1:0]                z_x, z_y, z_w;
  logic [BW-1:0]                z_btn;
  logic                         z_abs, z_vd;
  logic [BW-1:0]                down_m, up_m;
  logic [CW-1:0]                mx, my;
  logic                         new_abs;
  logic                         abs_after;
  logic [REC_W-1:0]             new_s_rec;
  logic [REC_W-1:0]             new_0_rec;
  logic [REC_W-1:0]             clr_rec;
  logic                         is_event;
  logic                         is_query;

  assign busy   = (state == ST_EXEC);
  assign accept = start && !busy;

  assign in_table = (32'(item.slot) < SLOT_COUNT);
  assign ev_ok    = in_table && !(include_system_pointer && (item.slot == '0)) &&
                    ({1'b0, item.slot} < event_slot_count);
  assign q_ok     = in_table && ({1'b0, item.slot} < query_slot_count);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      include_system_pointer <= 1'b1;
      include_individual     <= 1'b1;
      event_slot_count       <= mmea_pkg::RST_SLOT_COUNT;
      query_slot_count       <= mmea_pkg::RST_SLOT_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        mmea_pkg::REG_INCLUDE_SYSTEM: include_system_pointer <= cfg_data[0];
        mmea_pkg::REG_INCLUDE_INDIV:  include_individual     <= cfg_data[0];
        mmea_pkg::REG_EVENT_SLOTS:    event_slot_count       <= cfg_data;
        mmea_pkg::REG_QUERY_SLOTS:    query_slot_count       <= cfg_data;
        default: ;
      endcase
    end
  end

  // slot memory
  mmea_slot_ram #(
    .DEPTH (SLOT_COUNT),
    .AW    (SW),
    .DW    (REC_W)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (wr_data),
    .re      (accept),
    .raddr_a (SW'(item.slot)),
    .rdata_a (rd_a),
    .raddr_b ('0),
    .rdata_b (rd_b)
  );

  // system slot write of the previous item lands on the same edge as the read
  always_comb begin
    rec_s = (fwd_hit && (cur_addr == '0)) ? merge_rec : rd_a;
    rec_0 = fwd_hit ? merge_rec : rd_b;
  end

  assign s_x   = rec_s[X_LSB +: CW];
  assign s_y   = rec_s[Y_LSB +: CW];
  assign s_w   = rec_s[W_LSB +: CW];
  assign s_btn = rec_s[B_LSB +: BW];
  assign s_abs = rec_s[1];
  assign s_vd  = rec_s[0];
  assign z_x   = rec_0[X_LSB +: CW];
  assign z_y   = rec_0[Y_LSB +: CW];
  assign z_w   = rec_0[W_LSB +: CW];
  assign z_btn = rec_0[B_LSB +: BW];
  assign z_abs = rec_0[1];
  assign z_vd  = rec_0[0];

  assign is_event = (cur.kind == mmea_pkg::KIND_EVENT);
  assign is_query = (cur.kind == mmea_pkg::KIND_PEEK) || (cur.kind == mmea_pkg::KIND_READ);

  always_comb begin
    down_m  = BW'(cur.buttons_down) & BTN_MASK;
    up_m    = BW'(cur.buttons_up) & BTN_MASK;
    mx      = cur.move_x;
    my      = cur.move_y;
    new_abs = cur.mark_absolute ? 1'b1 : (cur.mark_relative ? 1'b0 : s_abs);
    abs_after = include_individual ? new_abs : s_abs;

    new_s_rec = {
      s_abs ? mx : s_x + mx,
      s_abs ? my : s_y + my,
      mmea_pkg::wheel_step(s_w, cur.wheel_event, cur.wheel_data),
      (s_btn | down_m) & ~up_m,
      new_abs,
      cur.mark_virtual_desktop
    };

    new_0_rec = {
      abs_after ? mx : z_x + mx,
      abs_after ? my : z_y + my,
      mmea_pkg::wheel_step(z_w, cur.wheel_event, cur.wheel_data),
      (z_btn | (down_m & SYS_MASK)) & ~(up_m & SYS_MASK),
      z_abs | cur.mark_absolute,
      z_vd | cur.mark_virtual_desktop
    };

    clr_rec = {{(3 * CW){1'b0}}, s_btn, s_abs, s_vd};
  end

  // write port: addressed slot in exec, system slot in the tail cycle
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_addr;
    wr_data = new_s_rec;
    case (state)
      ST_EXEC: begin
        if (is_event) begin
          wr_en = cur_ev_ok && include_individual;
        end else begin
          wr_en   = (cur.kind == mmea_pkg::KIND_READ) && cur_q_ok && !s_abs;
          wr_data = clr_rec;
        end
      end
      ST_FIN: begin
        wr_en   = merge_we;
        wr_addr = '0;
        wr_data = merge_rec;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_EXEC;
      ST_EXEC: state_next = ST_FIN;
      ST_FIN:  state_next = accept ? ST_EXEC : ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      merge_we     <= 1'b0;
      fwd_hit      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == ST_EXEC) && is_query;
      if (accept) begin
        fwd_hit <= (state == ST_FIN) && merge_we;
      end
      if (state == ST_EXEC) begin
        merge_we <= is_event && cur_ev_ok && include_system_pointer;
      end else if (state == ST_FIN) begin
        merge_we <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur       <= item;
      cur_addr  <= SW'(item.slot);
      cur_ev_ok <= ev_ok;
      cur_q_ok  <= q_ok;
    end
    if (state == ST_EXEC) begin
      merge_rec <= new_0_rec;
      if (cur_q_ok) begin
        result.pos_x           <= s_x;
        result.pos_y           <= s_y;
        result.wheel_count     <= s_w;
        result.button_bits     <= mmea_pkg::remap_buttons(mmea_pkg::BTN_IO_W'(s_btn));
        result.absolute_mode   <= s_abs;
        result.virtual_desktop <= s_vd;
        result.slot_valid      <= 1'b1;
      end else begin
        result <= '0;
      end
    end
  end

  // checks
  a_result_after_exec: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == ST_EXEC))
    else $error("result beat without a preceding exec cycle");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_merge_slot0: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && wr_en) |-> (wr_addr == '0))
    else $error("tail cycle write not aimed at the system slot");

  a_merge_needs_system: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && merge_we) |-> $past(include_system_pointer && is_event))
    else $error("system slot merge without a merging event");

endmodule

FILE: rtl/mmea_slot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmea_slot_ram
// Slot state memory: one write port, two registered read ports, per-entry
// valid bits so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module mmea_slot_ram #(
  parameter int DEPTH = mmea_pkg::DEF_SLOT_COUNT,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = 103
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  output logic [DW-1:0] rdata_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= vld[raddr_a] ? mem[raddr_a] : '0;
      rdata_b <= vld[raddr_b] ? mem[raddr_b] : '0;
    end
  end

endmodule

FILE: sim/mouse_slot_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mouse_slot_checker
// Watches the item, result and register ports of the pointer slot table,
// keeps its own copy of every slot and the register settings, works out the
// state report each peek or read should return and compares the strobed
// results in order.
// ----------------------------------------------------------------------------
module mouse_slot_checker
  import mmea_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  item_t                 item,
  input  result_t               result,
  input  logic                  result_valid,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    outstanding
);

  localparam int SLOTS = DEF_SLOT_COUNT;
  localparam logic [BTN_IO_W-1:0] BTN_MASK = (DEF_BUTTON_COUNT >= MAX_EVENT_BUTTONS) ?
    {BTN_IO_W{1'b1}} : BTN_IO_W'((1 << DEF_BUTTON_COUNT) - 1);

  logic              merge_system;
  logic              update_own;
  logic [CNT_W-1:0]  event_slots;
  logic [CNT_W-1:0]  query_slots;

  logic [COORD_W-1:0]  cur_x [SLOTS];
  logic [COORD_W-1:0]  cur_y [SLOTS];
  logic [COORD_W-1:0]  wheel [SLOTS];
  logic [BTN_IO_W-1:0] held  [SLOTS];
  logic                absm  [SLOTS];
  logic                vdesk [SLOTS];

  result_t slot_reports [$];
  int      mism = 0;

  function automatic logic [COORD_W-1:0] step_wheel(input logic [COORD_W-1:0] n,
                                                    input item_t it);
    if (!it.wheel_event || it.wheel_data == '0) return n;
    return it.wheel_data[WDATA_W-1] ? n - COORD_W'(1) : n + COORD_W'(1);
  endfunction

  task automatic apply_pointer_item(input item_t it);
    logic [SLOT_W-1:0]   s;
    logic [BTN_IO_W-1:0] dn;
    logic [BTN_IO_W-1:0] up;
    result_t             r;
    s  = it.slot;
    dn = it.buttons_down & BTN_MASK;
    up = it.buttons_up & BTN_MASK;
    r  = '0;
    if (it.kind == KIND_EVENT) begin
      if ((merge_system && s == '0) || CNT_W'(s) >= event_slots) return;
      if (update_own) begin
        if (absm[s]) begin
          cur_x[s] = it.move_x;
          cur_y[s] = it.move_y;
        end else begin
          cur_x[s] = cur_x[s] + it.move_x;
          cur_y[s] = cur_y[s] + it.move_y;
        end
        held[s] = (held[s] | dn) & ~up;
        if (it.mark_absolute) begin
          absm[s] = 1'b1;
        end else if (it.mark_relative) begin
          absm[s] = 1'b0;
        end
        vdesk[s] = it.mark_virtual_desktop;
        wheel[s] = step_wheel(wheel[s], it);
      end
      if (merge_system) begin
        if (absm[s]) begin
          cur_x[0] = it.move_x;
          cur_y[0] = it.move_y;
        end else begin
          cur_x[0] = cur_x[0] + it.move_x;
          cur_y[0] = cur_y[0] + it.move_y;
        end
        held[0] = (held[0] | (dn & SYS_BUTTON_MASK)) & ~(up & SYS_BUTTON_MASK);
        if (it.mark_absolute) absm[0] = 1'b1;
        if (it.mark_virtual_desktop) vdesk[0] = 1'b1;
        wheel[0] = step_wheel(wheel[0], it);
      end
    end else if (it.kind == KIND_PEEK || it.kind == KIND_READ) begin
      if (CNT_W'(s) < query_slots) begin
        r.pos_x           = cur_x[s];
        r.pos_y           = cur_y[s];
        r.wheel_count     = wheel[s];
        // buttons 2 and 3 trade places in the report
        r.button_bits     = {held[s][4], held[s][3], held[s][1], held[s][2], held[s][0]};
        r.absolute_mode   = absm[s];
        r.virtual_desktop = vdesk[s];
        r.slot_valid      = 1'b1;
        if (it.kind == KIND_READ && !absm[s]) begin
          cur_x[s] = '0;
          cur_y[s] = '0;
          wheel[s] = '0;
        end
      end
      slot_reports.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      merge_system = 1'b1;
      update_own   = 1'b1;
      event_slots  = RST_SLOT_COUNT;
      query_slots  = RST_SLOT_COUNT;
      for (int i = 0; i < SLOTS; i++) begin
        cur_x[i] = '0;
        cur_y[i] = '0;
        wheel[i] = '0;
        held[i]  = '0;
        absm[i]  = 1'b0;
        vdesk[i] = 1'b0;
      end
      slot_reports.delete();
    end else begin
      if (result_valid) begin
        if (slot_reports.size() == 0) begin
          if (mism < 10) $display("%0t: result beat with no query waiting", $time);
          mism++;
        end else begin
          want = slot_reports.pop_front();
          if (want.pos_x !== result.pos_x || want.pos_y !== result.pos_y ||
              want.wheel_count !== result.wheel_count ||
              want.button_bits !== result.button_bits ||
              want.absolute_mode !== result.absolute_mode ||
              want.virtual_desktop !== result.virtual_desktop ||
              want.slot_valid !== result.slot_valid) begin
            if (mism < 10) begin
              $display("%0t: expected x=%h y=%h wheel=%h btn=%b abs=%b vd=%b valid=%b",
                       $time, want.pos_x, want.pos_y, want.wheel_count, want.button_bits,
                       want.absolute_mode, want.virtual_desktop, want.slot_valid);
              $display("%0t:   actual x=%h y=%h wheel=%h btn=%b abs=%b vd=%b valid=%b",
                       $time, result.pos_x, result.pos_y, result.wheel_count,
                       result.button_bits, result.absolute_mode, result.virtual_desktop,
                       result.slot_valid);
            end
            mism++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_INCLUDE_SYSTEM: merge_system = cfg_data[0];
          REG_INCLUDE_INDIV:  update_own   = cfg_data[0];
          REG_EVENT_SLOTS:    event_slots  = cfg_data;
          REG_QUERY_SLOTS:    query_slots  = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) apply_pointer_item(item);
    end
    fail_count  <= mism;
    outstanding <= slot_reports.size();
  end

endmodule

FILE: sim/multi_mouse_event_accumulator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_mouse_event_accumulator_tb
// Drives directed and random pointer events, peeks and read-and-clear queries
// through several register settings and sender idle rates; a separate
// checker predicts and compares every state report.
// ----------------------------------------------------------------------------
module multi_mouse_event_accumulator_tb;
  import mmea_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_ITEMS  = 150;
  localparam int MAX_GAP      = 24;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  item_t                 item = '0;
  result_t               result;
  logic                  result_valid;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_INCLUDE_SYSTEM;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int idle_pct = 0;
  int cycles = 0;
  int fails;
  int waiting;

  multi_mouse_event_accumulator i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result       (result),
    .result_valid (result_valid),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  mouse_slot_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result       (result),
    .result_valid (result_valid),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fails),
    .outstanding  (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("FAIL multi_mouse_event_accumulator");
    $finish;
  end

  function automatic item_t pointer_event(input int s, input logic [31:0] x, y,
                                          input logic [4:0] dn, up, input logic wev,
                                          input logic [15:0] wd,
                                          input logic ab, rel, vd);
    item_t it;
    it.kind                 = KIND_EVENT;
    it.slot                 = SLOT_W'(s);
    it.move_x               = x;
    it.move_y               = y;
    it.buttons_down         = dn;
    it.buttons_up           = up;
    it.wheel_event          = wev;
    it.wheel_data           = wd;
    it.mark_absolute        = ab;
    it.mark_relative        = rel;
    it.mark_virtual_desktop = vd;
    return it;
  endfunction

  function automatic item_t slot_query(input logic [KIND_W-1:0] k, input int s);
    item_t it;
    it      = '0;
    it.kind = k;
    it.slot = SLOT_W'(s);
    return it;
  endfunction

  function automatic item_t random_pointer_item();
    item_t it;
    int    r;
    r = $urandom_range(99);
    if (r < 55) begin
      it.kind = KIND_EVENT;
    end else if (r < 75) begin
      it.kind = KIND_PEEK;
    end else if (r < 95) begin
      it.kind = KIND_READ;
    end else begin
      it.kind = KIND_NONE;
    end
    it.slot         = SLOT_W'($urandom_range(15));
    it.move_x       = ($urandom_range(3) == 0) ? $urandom : $urandom_range(200) - 100;
    it.move_y       = ($urandom_range(3) == 0) ? $urandom : $urandom_range(200) - 100;
    it.buttons_down = BTN_IO_W'($urandom);
    it.buttons_up   = $urandom_range(1) ? BTN_IO_W'($urandom) : '0;
    it.wheel_event  = 1'($urandom_range(1));
    case ($urandom_range(3))
      0: it.wheel_data = '0;
      1: it.wheel_data = $urandom_range(1) ? 16'h8000 : 16'h7fff;
      default: it.wheel_data = WDATA_W'($urandom);
    endcase
    it.mark_absolute        = ($urandom_range(99) < 15);
    it.mark_relative        = ($urandom_range(99) < 30);
    it.mark_virtual_desktop = 1'($urandom_range(1));
    return it;
  endfunction

  task automatic send_item(input item_t it);
    int gap;
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait for every state report, then let a trailing event merge finish
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic sys, indiv, input int evt, qry);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx[0] = REG_INCLUDE_SYSTEM; val[0] = CFG_DATA_W'(sys);
    idx[1] = REG_INCLUDE_INDIV;  val[1] = CFG_DATA_W'(indiv);
    idx[2] = REG_EVENT_SLOTS;    val[2] = CFG_DATA_W'(evt);
    idx[3] = REG_QUERY_SLOTS;    val[3] = CFG_DATA_W'(qry);
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_pct = 32;
    send_item(slot_query(KIND_PEEK, 0));
    // slot zero is no event target while the system pointer merges
    send_item(pointer_event(0, 32'd5, 32'd5, 5'h1f, 5'h00, 1, 16'd1, 1, 0, 1));
    send_item(pointer_event(1, 32'h7fffffff, 32'h80000000, 5'h1f, 5'h00, 1, 16'h7fff,
                            0, 0, 1));
    // wrap, and release winning over press on the same button
    send_item(pointer_event(1, 32'd1, 32'hffffffff, 5'h02, 5'h02, 1, 16'h8000, 0, 0, 0));
    send_item(pointer_event(1, 32'd0, 32'd0, 5'h00, 5'h00, 1, 16'h0000, 0, 1, 0));
    send_item(pointer_event(1, 32'd3, 32'd4, 5'h00, 5'h11, 0, 16'h0005, 0, 0, 1));
    send_item(slot_query(KIND_PEEK, 1));
    send_item(slot_query(KIND_PEEK, 0));
    send_item(pointer_event(2, 32'd100, 32'd200, 5'h04, 5'h00, 0, 16'h0000, 1, 0, 0));
    send_item(pointer_event(2, 32'd7, 32'd8, 5'h08, 5'h00, 1, 16'hffff, 0, 0, 0));
    send_item(slot_query(KIND_READ, 2));
    send_item(pointer_event(2, 32'd9, 32'd9, 5'h00, 5'h04, 0, 16'h0000, 1, 1, 1));
    send_item(pointer_event(2, 32'd11, 32'd12, 5'h00, 5'h00, 0, 16'h0000, 0, 1, 0));
    send_item(slot_query(KIND_READ, 2));
    send_item(slot_query(KIND_READ, 2));
    send_item(slot_query(KIND_READ, 0));
    send_item(slot_query(KIND_NONE, 1));
    send_item(pointer_event(15, 32'h80000000, 32'h7fffffff, 5'h1f, 5'h00, 1, 16'h0001,
                            0, 0, 0));
    send_item(slot_query(KIND_PEEK, 15));
    send_item(slot_query(KIND_READ, 1));
    send_item(slot_query(KIND_PEEK, 0));
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: program_regs(1, 1, 16, 16);
        1: program_regs(0, 1, 16, 16);
        2: program_regs(1, 0, 16, 8);
        3: program_regs(0, 0, 0, 0);
        4: program_regs(1, 1, 1, 1);
        5: program_regs(0, 1, 5, 12);
        6: program_regs(1, 1, $urandom_range(16), $urandom_range(16));
        default: program_regs(1, 1, 16, 16);
      endcase
      idle_pct = (p < 3) ? 32 : (p < 6) ? 80 : 0;
      repeat (PHASE_ITEMS) begin
        send_item(random_pointer_item());
        if ($urandom_range(99) == 0) settle();
      end
      settle();
    end

    if (fails == 0) begin
      $display("PASS multi_mouse_event_accumulator");
    end else begin
      $display("FAIL multi_mouse_event_accumulator");
    end
    $finish;
  end

endmodule
